[src/ycc_pkg.sv]
// Shared types, constants and helpers for the RGB to YCbCr 4:2:0 block.
// No dependencies; every other source file imports this package.
package ycc_pkg;

  // Frame geometry
  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;
  localparam int LineDepth = MaxWidth / 2;
  localparam int LineAw    = $clog2(LineDepth);
  localparam int CntW      = $clog2(MaxWidth);
  localparam int SizeW     = 13;
  localparam int CfgIdxW   = 1;

  // Fixed point: coefficients are round(c * 2^ScaleBits)
  localparam int ScaleBits = 10;
  localparam int PixW      = 8;
  localparam int PairW     = 9;
  localparam int BlkW      = 10;
  localparam int LumaAccW  = 19;
  localparam int ChrAccW   = 22;

  localparam logic [9:0] K_Y_R   = 10'd306;
  localparam logic [9:0] K_Y_G   = 10'd601;
  localparam logic [9:0] K_Y_B   = 10'd117;
  localparam logic [9:0] K_CB_R  = 10'd173;
  localparam logic [9:0] K_CB_G  = 10'd339;
  localparam logic [9:0] K_HALF  = 10'd512;
  localparam logic [9:0] K_CR_G  = 10'd429;
  localparam logic [9:0] K_CR_B  = 10'd83;

  localparam int LumaRound    = 1 << (ScaleBits - 1);
  localparam int ChromaBias   = (1 << (ScaleBits + 1)) - 1;
  localparam int ChromaShift  = ScaleBits + 2;
  localparam int ChromaOffset = 128;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_t;

  // R, G, B sums of a horizontal pixel pair
  typedef struct packed {
    logic [PairW-1:0] b;
    logic [PairW-1:0] g;
    logic [PairW-1:0] r;
  } rgb_sum_t;

  // Per-pixel control that rides along with the pixel
  typedef struct packed {
    logic     chroma;
    logic     frame_done;
    rgb_sum_t pair;
  } pix_tag_t;

  // Line store access for one accepted pixel
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [LineAw-1:0] addr;
    rgb_sum_t          wdata;
  } mem_req_t;

  // Drop bit 0, then hold the size within 2..hi
  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v,
                                                  input logic [SizeW-1:0] hi);
    logic [SizeW-1:0] e;
    e = {v[SizeW-1:1], 1'b0};
    if (e < SizeW'(2)) e = SizeW'(2);
    if (e > hi) e = hi;
    return e;
  endfunction

  function automatic logic [PixW-1:0] sat_u8(input logic signed [ChrAccW-1:0] v);
    logic [PixW-1:0] q;
    if (v < 0) q = '0;
    else if (v > ChrAccW'(255)) q = 8'd255;
    else q = v[PixW-1:0];
    return q;
  endfunction

endpackage

[src/rgb_to_ycbcr_420_subsampler.sv]
// Top level of the RGB to BT.601 YCbCr 4:2:0 converter.
// Depends on ycc_pkg, ycc_raster, ycc_line_mem and ycc_convert.
//
//   port group   dir   flow control        carries
//   in_*         in    in_valid/in_stall   red, green, blue of one pixel
//   out_*        out   out_valid/out_stall luma, chroma_valid, Cb, Cr, frame_done
//   cfg_*        in    cfg_wr_en           frame_width (0), frame_height (1)
//
// One pixel per clock while out_stall is low; three register stages deep.
// The line store (2048 x 27) takes one write and one read per cycle; the pair sum
// is fetched at acceptance of the odd-row pixel and used one stage later.
// Sync active-low reset clears counters and stage valids, resets sizes; the line
// store is not cleared. in_stall rises only when all three stages hold a word.
module rgb_to_ycbcr_420_subsampler (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ycc_pkg::PixW-1:0]     in_red,
  input  logic [ycc_pkg::PixW-1:0]     in_green,
  input  logic [ycc_pkg::PixW-1:0]     in_blue,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ycc_pkg::PixW-1:0]     out_luma,
  output logic                         out_chroma_valid,
  output logic [ycc_pkg::PixW-1:0]     out_blue_difference,
  output logic [ycc_pkg::PixW-1:0]     out_red_difference,
  output logic                         out_frame_done,
  input  logic                         cfg_wr_en,
  input  logic [ycc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ycc_pkg::SizeW-1:0]    cfg_wdata
);
  import ycc_pkg::*;

  logic     take;
  logic     accept;
  pix_tag_t tag;
  mem_req_t mem_req;
  rgb_sum_t line_data;

  assign in_stall = !take;
  assign accept   = in_valid && take;

  ycc_raster u_raster (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .tag       (tag),
    .mem_req   (mem_req)
  );

  ycc_line_mem u_line_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (line_data)
  );

  ycc_convert u_convert (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_red              (in_red),
    .in_green            (in_green),
    .in_blue             (in_blue),
    .tag                 (tag),
    .line_data           (line_data),
    .take                (take),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_luma            (out_luma),
    .out_chroma_valid    (out_chroma_valid),
    .out_blue_difference (out_blue_difference),
    .out_red_difference  (out_red_difference),
    .out_frame_done      (out_frame_done)
  );

endmodule

[src/ycc_line_mem.sv]
// Line store of even-row pair sums: one write and one registered read per cycle.
// Depends on ycc_pkg for the access and data types.
module ycc_line_mem (
  input  logic               clk,
  input  ycc_pkg::mem_req_t  req,
  output ycc_pkg::rgb_sum_t  rd_data
);
  import ycc_pkg::*;

  rgb_sum_t mem [LineDepth];
  rgb_sum_t rd_data_r;

  // Writes happen on even rows and read data is used only on odd rows, so a
  // read that matters never meets a write to the same entry at one edge.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/ycc_raster.sv]
// Frame size registers, raster position counters and horizontal pair sums.
// Depends on ycc_pkg; drives the line store request and the pixel tag.
module ycc_raster (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [ycc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ycc_pkg::SizeW-1:0]    cfg_wdata,
  input  logic                         accept,
  input  logic [ycc_pkg::PixW-1:0]     in_red,
  input  logic [ycc_pkg::PixW-1:0]     in_green,
  input  logic [ycc_pkg::PixW-1:0]     in_blue,
  output ycc_pkg::pix_tag_t            tag,
  output ycc_pkg::mem_req_t            mem_req
);
  import ycc_pkg::*;

  logic [SizeW-1:0] width_r, width_nxt;
  logic [SizeW-1:0] height_r, height_nxt;
  logic [CntW-1:0]  col_r, col_nxt;
  logic [CntW-1:0]  row_r, row_nxt;
  rgb_sum_t         pair_r, pair_nxt;

  logic [SizeW-1:0] w_lim, h_lim;
  logic [SizeW-1:0] col_inc, row_inc;
  logic             last_col, last_row;
  logic             odd_col, odd_row;
  rgb_sum_t         sum_now;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_WIDTH:  width_nxt  = cfg_wdata;
        CFG_HEIGHT: height_nxt = cfg_wdata;
      endcase
    end
  end

  assign w_lim    = clamp_size(width_r, SizeW'(MaxWidth));
  assign h_lim    = clamp_size(height_r, SizeW'(MaxHeight));
  assign col_inc  = {1'b0, col_r} + SizeW'(1);
  assign row_inc  = {1'b0, row_r} + SizeW'(1);
  assign last_col = col_inc >= w_lim;
  assign last_row = row_inc >= h_lim;
  assign odd_col  = col_r[0];
  assign odd_row  = row_r[0];

  assign sum_now.r = pair_r.r + PairW'(in_red);
  assign sum_now.g = pair_r.g + PairW'(in_green);
  assign sum_now.b = pair_r.b + PairW'(in_blue);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    pair_nxt = pair_r;
    if (accept) begin
      if (!odd_col) begin
        pair_nxt.r = PairW'(in_red);
        pair_nxt.g = PairW'(in_green);
        pair_nxt.b = PairW'(in_blue);
      end
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_inc[CntW-1:0];
      end else begin
        col_nxt = col_inc[CntW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SizeW'(1920);
      height_r <= SizeW'(1080);
      col_r    <= '0;
      row_r    <= '0;
      pair_r   <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      pair_r   <= pair_nxt;
    end
  end

  // Even rows park the pair sum, odd rows fetch it back from the same slot
  assign mem_req.wr_en = accept && odd_col && !odd_row;
  assign mem_req.rd_en = accept;
  assign mem_req.addr  = col_r[CntW-1:1];
  assign mem_req.wdata = sum_now;

  assign tag.chroma     = odd_col && odd_row;
  assign tag.frame_done = last_col && last_row;
  assign tag.pair       = sum_now;

endmodule

[src/ycc_convert.sv]
// Color math pipeline: pixel register, luma and block sums, then Cb/Cr output.
// Depends on ycc_pkg; the line store read data lines up with the first stage.
module ycc_convert (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [ycc_pkg::PixW-1:0]  in_red,
  input  logic [ycc_pkg::PixW-1:0]  in_green,
  input  logic [ycc_pkg::PixW-1:0]  in_blue,
  input  ycc_pkg::pix_tag_t         tag,
  input  ycc_pkg::rgb_sum_t         line_data,
  output logic                      take,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic [ycc_pkg::PixW-1:0]  out_luma,
  output logic                      out_chroma_valid,
  output logic [ycc_pkg::PixW-1:0]  out_blue_difference,
  output logic [ycc_pkg::PixW-1:0]  out_red_difference,
  output logic                      out_frame_done
);
  import ycc_pkg::*;

  // stage 1: raw pixel
  logic            v1_r;
  logic [PixW-1:0] red1_r, green1_r, blue1_r;
  pix_tag_t        tag1_r;
  // stage 2: luma and four-pixel sums
  logic            v2_r;
  logic [PixW-1:0] luma2_r, luma2_nxt;
  logic            chroma2_r, done2_r;
  logic [BlkW-1:0] rs2_r, gs2_r, bs2_r;
  logic [BlkW-1:0] rs2_nxt, gs2_nxt, bs2_nxt;
  // output stage
  logic            v3_r;
  logic [PixW-1:0] luma3_r;
  logic            chroma3_r, done3_r;
  logic [PixW-1:0] cb3_r, cr3_r, cb3_nxt, cr3_nxt;

  logic en1, en2, en3;
  logic [LumaAccW-1:0]       luma_acc;
  logic signed [ChrAccW-1:0] rs_s, gs_s, bs_s;
  logic signed [ChrAccW-1:0] cb_acc, cr_acc, cb_q, cr_q;

  assign en3  = !v3_r || !out_stall;
  assign en2  = !v2_r || en3;
  assign en1  = !v1_r || en2;
  assign take = en1;

  always_comb begin
    luma_acc = LumaAccW'(K_Y_R) * LumaAccW'(red1_r)
             + LumaAccW'(K_Y_G) * LumaAccW'(green1_r)
             + LumaAccW'(K_Y_B) * LumaAccW'(blue1_r)
             + LumaAccW'(LumaRound);
    if (|luma_acc[LumaAccW-1:ScaleBits+PixW]) luma2_nxt = 8'd255;
    else luma2_nxt = luma_acc[ScaleBits+PixW-1:ScaleBits];
    rs2_nxt = BlkW'(tag1_r.pair.r) + BlkW'(line_data.r);
    gs2_nxt = BlkW'(tag1_r.pair.g) + BlkW'(line_data.g);
    bs2_nxt = BlkW'(tag1_r.pair.b) + BlkW'(line_data.b);
  end

  always_comb begin
    rs_s   = signed'(ChrAccW'(rs2_r));
    gs_s   = signed'(ChrAccW'(gs2_r));
    bs_s   = signed'(ChrAccW'(bs2_r));
    cb_acc = signed'(ChrAccW'(K_HALF)) * bs_s - signed'(ChrAccW'(K_CB_R)) * rs_s
           - signed'(ChrAccW'(K_CB_G)) * gs_s + signed'(ChrAccW'(ChromaBias));
    cr_acc = signed'(ChrAccW'(K_HALF)) * rs_s - signed'(ChrAccW'(K_CR_G)) * gs_s
           - signed'(ChrAccW'(K_CR_B)) * bs_s + signed'(ChrAccW'(ChromaBias));
    // arithmetic shift floors toward minus infinity
    cb_q   = (cb_acc >>> ChromaShift) + signed'(ChrAccW'(ChromaOffset));
    cr_q   = (cr_acc >>> ChromaShift) + signed'(ChrAccW'(ChromaOffset));
    cb3_nxt = chroma2_r ? sat_u8(cb_q) : '0;
    cr3_nxt = chroma2_r ? sat_u8(cr_q) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      red1_r   <= in_red;
      green1_r <= in_green;
      blue1_r  <= in_blue;
      tag1_r   <= tag;
    end
    if (en2 && v1_r) begin
      luma2_r   <= luma2_nxt;
      chroma2_r <= tag1_r.chroma;
      done2_r   <= tag1_r.frame_done;
      rs2_r     <= rs2_nxt;
      gs2_r     <= gs2_nxt;
      bs2_r     <= bs2_nxt;
    end
    if (en3 && v2_r) begin
      luma3_r   <= luma2_r;
      chroma3_r <= chroma2_r;
      done3_r   <= done2_r;
      cb3_r     <= cb3_nxt;
      cr3_r     <= cr3_nxt;
    end
  end

  assign out_valid           = v3_r;
  assign out_luma            = luma3_r;
  assign out_chroma_valid    = chroma3_r;
  assign out_blue_difference = cb3_r;
  assign out_red_difference  = cr3_r;
  assign out_frame_done      = done3_r;

  // input backs up only when every stage holds a word
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !take |-> (v1_r && v2_r && v3_r))
    else $error("input stalled with a free stage");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !en2) |=> ($stable(luma2_r) && $stable(chroma2_r) && v2_r))
    else $error("middle stage changed while held");

  a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_chroma_valid) |->
      (out_blue_difference == '0 && out_red_difference == '0))
    else $error("chroma fields set without a completed block");

endmodule

[bench/rgb_to_ycbcr_420_subsampler_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for rgb_to_ycbcr_420_subsampler: directed table, then random frames.
// Uses ycc_pkg for port widths, size limits and register indexes, plus the DUT.
module rgb_to_ycbcr_420_subsampler_tb;
  import ycc_pkg::*;

  localparam int TotalPixels   = 1172;
  localparam int QuietTail     = 150;
  localparam int BacklogAt     = 400;
  localparam int BacklogLead   = 80;
  localparam int BacklogCycles = 64;
  localparam int CycleLimit    = 200000;

  function automatic longint fix_coef(input longint k);
    return ((k << ScaleBits) + 50000) / 100000;
  endfunction

  localparam longint CoefYR    = fix_coef(29900);
  localparam longint CoefYG    = fix_coef(58700);
  localparam longint CoefYB    = fix_coef(11400);
  localparam longint CoefCbR   = fix_coef(16874);
  localparam longint CoefCbG   = fix_coef(33126);
  localparam longint CoefHalf  = fix_coef(50000);
  localparam longint CoefCrG   = fix_coef(41869);
  localparam longint CoefCrB   = fix_coef(8131);
  localparam longint LumaRnd   = longint'(1) << (ScaleBits - 1);
  localparam longint ChromaRnd = (longint'(1) << (ScaleBits + 1)) - 1;

  typedef struct packed {
    logic [PixW-1:0] luma;
    logic            chroma_valid;
    logic [PixW-1:0] blue_diff;
    logic [PixW-1:0] red_diff;
    logic            frame_done;
  } ycc_word_t;

  typedef struct packed {
    bit               is_reg;
    cfg_reg_t         reg_sel;
    logic [SizeW-1:0] reg_val;
    logic [PixW-1:0]  r;
    logic [PixW-1:0]  g;
    logic [PixW-1:0]  b;
    bit               typed;
    ycc_word_t        want;
  } stim_row_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [PixW-1:0]     in_red    = '0;
  logic [PixW-1:0]     in_green  = '0;
  logic [PixW-1:0]     in_blue   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [PixW-1:0]     out_luma;
  logic                out_chroma_valid;
  logic [PixW-1:0]     out_blue_difference;
  logic [PixW-1:0]     out_red_difference;
  logic                out_frame_done;
  logic                cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [SizeW-1:0]    cfg_wdata = '0;

  rgb_to_ycbcr_420_subsampler u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_red              (in_red),
    .in_green            (in_green),
    .in_blue             (in_blue),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_luma            (out_luma),
    .out_chroma_valid    (out_chroma_valid),
    .out_blue_difference (out_blue_difference),
    .out_red_difference  (out_red_difference),
    .out_frame_done      (out_frame_done),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Shadow of the converter state
  logic [SizeW-1:0] frame_w_reg = 13'd1920;
  logic [SizeW-1:0] frame_h_reg = 13'd1080;
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;
  logic [8:0]       even_r = '0, even_g = '0, even_b = '0;
  logic [26:0]      upper_pairs [LineDepth];
  bit               upper_valid [LineDepth];

  ycc_word_t pending_words [$];
  stim_row_t directed_rows [$];
  int        pixels_sent = 0;
  int        mismatches = 0;
  bit        backlog_done = 1'b0;
  bit        backlog_busy = 1'b0;
  logic      calm;

  assign calm = (pixels_sent >= TotalPixels - QuietTail);

  function automatic int unsigned eff_size(input logic [SizeW-1:0] val, input int unsigned hi);
    int unsigned s;
    s = 32'({val[SizeW-1:1], 1'b0});
    if (s < 2) s = 2;
    if (s > hi) s = hi;
    return s;
  endfunction

  function automatic logic [PixW-1:0] clip8(input longint v);
    if (v < 0) return '0;
    if (v > 255) return 8'd255;
    return v[PixW-1:0];
  endfunction

  function automatic ycc_word_t convert_pixel(input logic [PixW-1:0] r, g, b);
    ycc_word_t   w;
    int unsigned fw, fh, slot;
    longint      rr, gg, bb, rs, gs, bs, cb, cr;
    logic [26:0] above;
    bit          last_col, last_row;
    fw = eff_size(frame_w_reg, MaxWidth);
    fh = eff_size(frame_h_reg, MaxHeight);
    slot = (col_pos >> 1) % LineDepth;
    rr = longint'(r);
    gg = longint'(g);
    bb = longint'(b);
    w = '0;
    w.luma = clip8((CoefYR * rr + CoefYG * gg + CoefYB * bb + LumaRnd) >>> ScaleBits);
    if (col_pos % 2 == 0) begin
      even_r = {1'b0, r};
      even_g = {1'b0, g};
      even_b = {1'b0, b};
    end else begin
      rs = rr + even_r;
      gs = gg + even_g;
      bs = bb + even_b;
      if (row_pos % 2 == 0) begin
        upper_pairs[slot] = {bs[8:0], gs[8:0], rs[8:0]};
        upper_valid[slot] = 1'b1;
      end else begin
        above = upper_valid[slot] ? upper_pairs[slot] : '0;
        rs += above[8:0];
        gs += above[17:9];
        bs += above[26:18];
        cb = ChromaRnd - CoefCbR * rs - CoefCbG * gs + CoefHalf * bs;
        cr = ChromaRnd + CoefHalf * rs - CoefCrG * gs - CoefCrB * bs;
        w.chroma_valid = 1'b1;
        w.blue_diff = clip8((cb >>> (ScaleBits + 2)) + 128);
        w.red_diff  = clip8((cr >>> (ScaleBits + 2)) + 128);
      end
    end
    last_col = (col_pos + 1 >= fw);
    last_row = (row_pos + 1 >= fh);
    w.frame_done = last_col && last_row;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : ((row_pos + 1) & 12'hFFF);
    end else begin
      col_pos = (col_pos + 1) & 12'hFFF;
    end
    return w;
  endfunction

  // A wider line on an odd row would read pair sums that were never stored
  function automatic bit width_ok(input logic [SizeW-1:0] val);
    int unsigned w, i;
    if (row_pos % 2 == 0) return 1'b1;
    w = eff_size(val, MaxWidth);
    for (i = 0; i < w / 2; i++)
      if (!upper_valid[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void put_pix(input logic [PixW-1:0] r, g, b);
    stim_row_t row;
    row = '0;
    row.r = r;
    row.g = g;
    row.b = b;
    directed_rows.push_back(row);
  endfunction

  function automatic void put_known(input logic [PixW-1:0] r, g, b, input ycc_word_t want);
    stim_row_t row;
    row = '0;
    row.r = r;
    row.g = g;
    row.b = b;
    row.typed = 1'b1;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void put_reg(input cfg_reg_t sel, input logic [SizeW-1:0] val);
    stim_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [PixW-1:0] rand_comp();
    case ($urandom_range(4))
      0: return '0;
      1: return 8'd255;
      default: return PixW'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [SizeW-1:0] pick_size(input int unsigned small_hi, input bit narrow);
    if (narrow || $urandom_range(7) != 0) return SizeW'($urandom_range(small_hi));
    case ($urandom_range(5))
      0: return 13'd1;
      1: return 13'd4094;
      2: return 13'd4096;
      3: return 13'd4097;
      4: return 13'd8190;
      default: return 13'd8191;
    endcase
  endfunction

  task automatic send_pixel(input logic [PixW-1:0] r, g, b, input bit typed,
                            input ycc_word_t want);
    ycc_word_t pred;
    if (!calm && $urandom_range(4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = convert_pixel(r, g, b);
    pending_words.push_back(typed ? want : pred);
    pixels_sent++;
  endtask

  // Sizes change only once the pipe has drained
  task automatic write_reg(input cfg_reg_t sel, input logic [SizeW-1:0] val);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (sel == CFG_WIDTH) frame_w_reg = val;
    else frame_h_reg = val;
  endtask

  initial begin : stimulus
    stim_row_t        row;
    logic [SizeW-1:0] size_val;
    int unsigned      choice, count;
    bit               narrow_next, wide, cfg_ok;

    // Black and white right after reset, default sizes
    put_known(8'd0, 8'd0, 8'd0, {8'd0, 1'b0, 8'd0, 8'd0, 1'b0});
    put_known(8'd255, 8'd255, 8'd255, {8'd255, 1'b0, 8'd0, 8'd0, 1'b0});
    // Odd and too small sizes, shrunk mid-frame: counters wrap at once
    put_reg(CFG_WIDTH, 13'd3);
    put_reg(CFG_HEIGHT, 13'd1);
    put_pix(8'd17, 8'd200, 8'd90);
    put_pix(8'd0, 8'd0, 8'd0);
    put_pix(8'd0, 8'd0, 8'd0);
    // 2x2 frames
    repeat (3) put_known(8'd0, 8'd0, 8'd0, {8'd0, 1'b0, 8'd0, 8'd0, 1'b0});
    put_known(8'd0, 8'd0, 8'd0, {8'd0, 1'b1, 8'd128, 8'd128, 1'b1});
    repeat (3) put_known(8'd255, 8'd255, 8'd255, {8'd255, 1'b0, 8'd0, 8'd0, 1'b0});
    put_known(8'd255, 8'd255, 8'd255, {8'd255, 1'b1, 8'd128, 8'd128, 1'b1});
    repeat (4) put_pix(8'd255, 8'd0, 8'd0);
    // Oversized frame, then cut back to 2x2 partway through the first line
    put_reg(CFG_WIDTH, 13'd8191);
    put_reg(CFG_HEIGHT, 13'd8191);
    repeat (3) put_pix(8'd0, 8'd0, 8'd255);
    put_reg(CFG_WIDTH, 13'd0);
    put_reg(CFG_HEIGHT, 13'd0);
    put_pix(8'd0, 8'd255, 8'd255);
    put_pix(8'd255, 8'd255, 8'd0);

    while (!rst_n) @(posedge clk);
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_reg) write_reg(row.reg_sel, row.reg_val);
      else send_pixel(row.r, row.g, row.b, row.typed, row.want);
    end

    narrow_next = 1'b0;
    while (pixels_sent < TotalPixels) begin
      choice = $urandom_range(9);
      // keep pixels flowing around the long output hold so the pipe backs up
      cfg_ok = backlog_done ? !backlog_busy : (pixels_sent + BacklogLead < BacklogAt);
      if (cfg_ok && (narrow_next || choice < 4)) begin
        size_val = pick_size(17, narrow_next);
        if (width_ok(size_val)) write_reg(CFG_WIDTH, size_val);
      end
      if (cfg_ok && choice >= 2 && choice < 6) write_reg(CFG_HEIGHT, pick_size(11, 1'b0));
      // wide lines never finish; keep them short and narrow down next time
      wide = eff_size(frame_w_reg, MaxWidth) > 64;
      narrow_next = wide;
      count = wide ? $urandom_range(24, 4) : $urandom_range(64, 8);
      repeat (count) send_pixel(rand_comp(), rand_comp(), rand_comp(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin : out_stall_gen
    while (!rst_n) @(posedge clk);
    forever begin
      if (!backlog_done && pixels_sent >= BacklogAt) begin
        // long hold so the pipe fills and pushes back on the input
        backlog_busy = 1'b1;
        backlog_done = 1'b1;
        out_stall <= 1'b1;
        repeat (BacklogCycles) @(posedge clk);
        backlog_busy = 1'b0;
      end else if (!calm && $urandom_range(3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(5, 1)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat (calm ? 1 : $urandom_range(12, 1)) @(posedge clk);
      end
    end
  end

  function automatic void check_field(input string name, input logic [PixW-1:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : out_check
    ycc_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("word with nothing expected: luma %0d", out_luma);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        check_field("luma", want.luma, out_luma);
        check_field("chroma_valid", PixW'(want.chroma_valid), PixW'(out_chroma_valid));
        check_field("blue_difference", want.blue_diff, out_blue_difference);
        check_field("red_difference", want.red_diff, out_red_difference);
        check_field("frame_done", PixW'(want.frame_done), PixW'(out_frame_done));
      end
    end
  end

  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
